// ----- design/mbps_pkg.sv -----
// shared types, constants and register codes for the masked byte pattern search
package mbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int OFFSET_BITS = 32;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int MATCH_OFF_W = 32;
  localparam int PAT_W       = 2 * CFG_DATA_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_MASK_LOW     = 3'd2,
    CFG_MASK_HIGH    = 3'd3,
    CFG_PATTERN_LEN  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [MATCH_OFF_W-1:0] match_offset;
    logic                   overflow;
  } out_item_t;

  // per-cycle control for the window cells
  typedef struct packed {
    logic shift;
    logic flush;
  } cell_ctl_t;

endpackage

// ----- design/mbps_cell.sv -----
// one window cell: holds a buffer byte and its fill flag, compares its incoming byte
module mbps_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mbps_pkg::cell_ctl_t       ctl,
  input  logic [mbps_pkg::BYTE_W-1:0] byte_in,
  input  logic                      valid_in,
  input  logic [mbps_pkg::BYTE_W-1:0] pat,
  input  logic [mbps_pkg::BYTE_W-1:0] msk,
  input  logic                      active,
  output logic [mbps_pkg::BYTE_W-1:0] byte_r,
  output logic                      valid_r,
  output logic                      hit
);

  logic valid_nxt;

  // compare uses the byte this cell holds after the shift
  assign hit = !active || (valid_in && (((byte_in ^ pat) & msk) == '0));

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.flush) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt = valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

endmodule

// ----- design/mbps_out_stage.sv -----
// result holding register between the search logic and the output channel
module mbps_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  mbps_pkg::out_item_t load_data,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output mbps_pkg::out_item_t out_data
);

  logic                valid_r;
  logic                valid_nxt;
  mbps_pkg::out_item_t data_r;

  // full and not drained this cycle
  assign busy      = valid_r && out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

// ----- design/masked_byte_pattern_search.sv -----
// top level of the masked byte pattern search over a streamed byte buffer
// throughput: one byte per cycle, also across buffer boundaries, unless a held result stalls the input
// latency: the result of a buffer is valid the cycle after its last byte is taken
// the per-cycle work is one shift of the cell row plus a parallel masked compare
// reset (rst_n low, synchronous) clears configuration, fill flags, counters and output
// no clearing pass: the block takes bytes in the first cycle after reset
module masked_byte_pattern_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mbps_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mbps_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NCELL = mbps_pkg::MAX_PATTERN;
  localparam int BW    = mbps_pkg::BYTE_W;
  localparam int OW    = mbps_pkg::OFFSET_BITS;
  localparam int LW    = mbps_pkg::LEN_W;

  // configuration registers
  logic [mbps_pkg::CFG_DATA_W-1:0] pat_lo_r, pat_hi_r, msk_lo_r, msk_hi_r;
  logic [LW-1:0]                   len_r;
  logic                            cfg_we;

  // per-buffer state
  logic [OW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          seen_r, seen_nxt;
  logic [OW-1:0] first_r, first_nxt;

  // cell row
  mbps_pkg::cell_ctl_t ctl;
  logic [BW-1:0]       cell_pat [NCELL];
  logic [BW-1:0]       cell_msk [NCELL];
  logic [NCELL-1:0]    cell_act;
  logic [BW-1:0]       win_byte [NCELL];
  logic [NCELL-1:0]    win_valid;
  logic [NCELL-1:0]    hit;

  logic                in_accept;
  logic                last_txn;
  logic                cnt_sat;
  logic                len_ok;
  logic                match_now;
  logic [OW-1:0]       cnt_new;
  logic                ovf_new;
  logic                out_busy;
  mbps_pkg::out_item_t result;

  // ---------------------------------------------------------------------------
  // configuration port: always ready, unknown indexes are dropped
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      msk_lo_r <= '0;
      msk_hi_r <= '0;
      len_r    <= '0;
    end else if (cfg_we) begin
      unique case (mbps_pkg::cfg_reg_t'(cfg_index))
        mbps_pkg::CFG_PATTERN_LOW:  pat_lo_r <= cfg_data;
        mbps_pkg::CFG_PATTERN_HIGH: pat_hi_r <= cfg_data;
        mbps_pkg::CFG_MASK_LOW:     msk_lo_r <= cfg_data;
        mbps_pkg::CFG_MASK_HIGH:    msk_hi_r <= cfg_data;
        mbps_pkg::CFG_PATTERN_LEN:  len_r    <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pattern alignment: window cell i (newest byte at cell 0) is checked against
  // pattern byte len-1-i; cells at or beyond the length are left out
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [mbps_pkg::PAT_W-1:0] pat_all;
    logic [mbps_pkg::PAT_W-1:0] msk_all;
    logic [LW-1:0]              k;
    pat_all = {pat_hi_r, pat_lo_r};
    msk_all = {msk_hi_r, msk_lo_r};
    for (int i = 0; i < NCELL; i++) begin
      k           = len_r - LW'(1) - LW'(i);
      cell_pat[i] = pat_all[k[mbps_pkg::IDX_W-1:0] * BW +: BW];
      cell_msk[i] = msk_all[k[mbps_pkg::IDX_W-1:0] * BW +: BW];
      cell_act[i] = LW'(i) < len_r;
    end
  end

  // ---------------------------------------------------------------------------
  // input handshake: the only back pressure is a result still waiting downstream
  // ---------------------------------------------------------------------------
  assign in_stall  = out_busy;
  assign in_accept = in_valid && !in_stall;
  assign last_txn  = in_accept && in_data.last_byte;

  assign ctl.shift = in_accept;
  assign ctl.flush = last_txn;

  // ---------------------------------------------------------------------------
  // the cell row: bytes move one cell further per accepted transaction, and the
  // fill flags move with them so no position before the buffer start can match
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    logic [BW-1:0] byte_in;
    logic          valid_in;

    if (g == 0) begin : g_head
      assign byte_in  = in_data.data_byte;
      assign valid_in = 1'b1;
    end else begin : g_body
      assign byte_in  = win_byte[g-1];
      assign valid_in = win_valid[g-1];
    end

    mbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (byte_in),
      .valid_in (valid_in),
      .pat      (cell_pat[g]),
      .msk      (cell_msk[g]),
      .active   (cell_act[g]),
      .byte_r   (win_byte[g]),
      .valid_r  (win_valid[g]),
      .hit      (hit[g])
    );
  end

  // ---------------------------------------------------------------------------
  // byte counter, saturating; a byte taken at full count marks overflow
  // ---------------------------------------------------------------------------
  assign cnt_sat = &cnt_r;
  assign cnt_new = cnt_sat ? cnt_r : cnt_r + OW'(1);
  assign ovf_new = ovf_r || cnt_sat;

  // zero length and lengths beyond the cell row never match
  assign len_ok    = (len_r != '0) && (len_r <= LW'(NCELL));
  assign match_now = in_accept && len_ok && (&hit) && !ovf_new && !seen_r;

  // result of the buffer, including a match found on its last byte
  always_comb begin
    result.found        = seen_r || match_now;
    result.match_offset = '0;
    if (match_now) begin
      result.match_offset = mbps_pkg::MATCH_OFF_W'(cnt_new - OW'(len_r));
    end else if (seen_r) begin
      result.match_offset = mbps_pkg::MATCH_OFF_W'(first_r);
    end
    result.overflow     = ovf_new;
  end

  // per-buffer state update, cleared after the last byte
  always_comb begin
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    seen_nxt  = seen_r;
    first_nxt = first_r;
    if (last_txn) begin
      cnt_nxt   = '0;
      ovf_nxt   = 1'b0;
      seen_nxt  = 1'b0;
      first_nxt = '0;
    end else if (in_accept) begin
      cnt_nxt = cnt_new;
      ovf_nxt = ovf_new;
      if (match_now) begin
        seen_nxt  = 1'b1;
        first_nxt = cnt_new - OW'(len_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      seen_r  <= 1'b0;
      first_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      seen_r  <= seen_nxt;
      first_r <= first_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // output register: holds one result while the next buffer streams in
  // ---------------------------------------------------------------------------
  mbps_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (last_txn),
    .load_data (result),
    .busy      (out_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // the last byte of a buffer always yields a result on the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    last_txn |=> out_valid)
    else $error("no result after last byte");

  // a not-found result reports a zero offset
  a_no_match_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.match_offset == '0))
    else $error("offset set without match");

  // fill flags: cell 1 is filled only when the newest cell 0 is filled
  a_fill_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    win_valid[1] |-> win_valid[0])
    else $error("fill flags out of order");

  // fill flags and counter agree at the start of a buffer
  a_empty_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (!win_valid[0] && !seen_r && !ovf_r))
    else $error("stale state at buffer start");

  // a recorded match never sits beyond the bytes counted so far
  a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (first_r < cnt_r))
    else $error("match offset beyond byte count");

endmodule

// ----- sim/masked_byte_pattern_search_tb.sv -----
// self-checking testbench for the masked byte pattern search
`timescale 1ns / 100ps

module masked_byte_pattern_search_tb;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_BYTES   = 645;
  localparam int SETTING_BYTES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam mbps_pkg::out_item_t NO_WANT = '0;

  // kinds of rows in the directed table
  typedef enum logic {
    STEP_BYTE,
    STEP_WRITE
  } step_kind_t;

  typedef struct packed {
    step_kind_t          kind;
    mbps_pkg::cfg_reg_t  reg_idx;
    logic [63:0]         value;
    logic [7:0]          data;
    logic                last;
    logic                typed;
    mbps_pkg::out_item_t want;
  } dir_step_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  mbps_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  mbps_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the registers
  logic [63:0] pat_lo, pat_hi, msk_lo, msk_hi;
  logic [4:0]  pat_len;
  // predictor copy of the per-buffer state, newest byte at index 0
  logic [7:0]  win [16];
  logic [31:0] seen_cnt;
  logic        hit_seen;
  logic [31:0] hit_off;
  logic        cnt_sat;

  mbps_pkg::out_item_t pending_results [$];
  int unsigned mismatch_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_go = 0;
  bit          hold_done = 0;
  int          hold_left = 0;
  longint      cycle_cnt = 0;

  // directed table: expectations typed in only where obvious
  dir_step_t dir_tab [0:23] = '{
    // after reset the length is zero, nothing can match
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'h00, 1'b1, 1'b1, '{1'b0, 32'd0, 1'b0}},
    '{STEP_WRITE, mbps_pkg::CFG_PATTERN_LOW, 64'hFF, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, mbps_pkg::CFG_MASK_LOW, 64'hFF, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, mbps_pkg::CFG_PATTERN_LEN, 64'd1, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'hFF, 1'b1, 1'b1, '{1'b1, 32'd1, 1'b0}},
    // single byte buffer
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'hFF, 1'b1, 1'b1, '{1'b1, 32'd0, 1'b0}},
    // length above the maximum never matches
    '{STEP_WRITE, mbps_pkg::CFG_PATTERN_LEN, 64'h1F, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'hFF, 1'b1, 1'b1, '{1'b0, 32'd0, 1'b0}},
    // all-wildcard pattern of three bytes
    '{STEP_WRITE, mbps_pkg::CFG_MASK_LOW, 64'h0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, mbps_pkg::CFG_PATTERN_LEN, 64'd3, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'h12, 1'b0, 1'b0, NO_WANT},
    // buffer shorter than the pattern
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'h34, 1'b1, 1'b1, '{1'b0, 32'd0, 1'b0}},
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'hAB, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'hCD, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'hEF, 1'b1, 1'b1, '{1'b1, 32'd0, 1'b0}},
    // nibble masks on a two byte pattern
    '{STEP_WRITE, mbps_pkg::CFG_PATTERN_HIGH, '1, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, mbps_pkg::CFG_MASK_HIGH, '1, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, mbps_pkg::CFG_PATTERN_LOW, 64'hA55A, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, mbps_pkg::CFG_MASK_LOW, 64'hF00F, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, mbps_pkg::CFG_PATTERN_LEN, 64'd2, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'h3C, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'h7A, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE, mbps_pkg::CFG_PATTERN_LOW, 64'h0, 8'hA0, 1'b1, 1'b0, NO_WANT}
  };

  masked_byte_pattern_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // clear the per-buffer part of the predictor
  function automatic void clear_search();
    for (int i = 0; i < 16; i++) win[i] = 8'h00;
    seen_cnt = '0;
    hit_seen = 1'b0;
    hit_off  = '0;
    cnt_sat  = 1'b0;
  endfunction

  function automatic void apply_reg(mbps_pkg::cfg_reg_t idx, logic [63:0] v);
    case (idx)
      mbps_pkg::CFG_PATTERN_LOW:  pat_lo = v;
      mbps_pkg::CFG_PATTERN_HIGH: pat_hi = v;
      mbps_pkg::CFG_MASK_LOW:     msk_lo = v;
      mbps_pkg::CFG_MASK_HIGH:    msk_hi = v;
      mbps_pkg::CFG_PATTERN_LEN:  pat_len = v[4:0];
      default: ;
    endcase
  endfunction

  // advance the search by one byte, returns 1 when the byte closes a buffer
  function automatic bit search_step(input logic [7:0] b, input logic lst,
                                     output mbps_pkg::out_item_t res);
    logic [127:0] pat;
    logic [127:0] msk;
    bit hit;
    int unsigned len;
    pat = {pat_hi, pat_lo};
    msk = {msk_hi, msk_lo};
    len = pat_len;
    res = '0;
    for (int i = 15; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    // counter saturates and flags overflow instead of wrapping
    if (seen_cnt != '1) seen_cnt = seen_cnt + 1;
    else cnt_sat = 1'b1;
    if (!cnt_sat && !hit_seen && len >= 1 && len <= mbps_pkg::MAX_PATTERN &&
        seen_cnt >= len) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (((win[len-1-k] ^ pat[8*k +: 8]) & msk[8*k +: 8]) != 8'h00) hit = 1'b0;
      end
      if (hit) begin
        hit_seen = 1'b1;
        hit_off  = seen_cnt - len;
      end
    end
    if (!lst) return 1'b0;
    res.found        = hit_seen;
    res.match_offset = hit_seen ? hit_off : 32'd0;
    res.overflow     = cnt_sat;
    clear_search();
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // offer one byte, hold it until the block takes it, then predict
  task automatic push_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input mbps_pkg::out_item_t want);
    mbps_pkg::out_item_t pred;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{data_byte: b, last_byte: lst};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (search_step(b, lst, pred)) pending_results.push_back(typed ? want : pred);
  endtask

  // stop offering and wait until every expected transaction is out
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input mbps_pkg::cfg_reg_t idx, input logic [63:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // new register setting; slot zero forces the widest exact pattern
  task automatic new_setting(input int unsigned slot);
    int unsigned r;
    logic [4:0]  len;
    logic [63:0] v;
    logic [63:0] m_lo, m_hi;
    r = $urandom_range(99);
    if (slot == 0) len = 5'd16;
    else if (r < 6) len = 5'd0;
    else if (r < 14) len = 5'd16;
    else if (r < 20) len = 5'($urandom_range(17, 31));
    else len = 5'($urandom_range(1, 16));
    r = $urandom_range(9);
    if (slot == 0 || r < 2) begin
      m_lo = '1;
      m_hi = '1;
    end else if (r < 3) begin
      m_lo = '0;
      m_hi = '0;
    end else if (r < 6) begin
      // sparse masks leave many wildcard bits
      m_lo = rand64() & rand64();
      m_hi = rand64() & rand64();
    end else begin
      m_lo = rand64();
      m_hi = rand64();
    end
    r = $urandom_range(9);
    write_reg(mbps_pkg::CFG_PATTERN_LOW, (r == 0) ? '1 : (r == 1) ? '0 : rand64());
    write_reg(mbps_pkg::CFG_PATTERN_HIGH, (r == 0) ? '1 : (r == 1) ? '0 : rand64());
    write_reg(mbps_pkg::CFG_MASK_LOW, m_lo);
    write_reg(mbps_pkg::CFG_MASK_HIGH, m_hi);
    // upper data bits are don't-care for the length register
    v = ($urandom_range(3) == 0) ? rand64() : 64'd0;
    v[4:0] = len;
    write_reg(mbps_pkg::CFG_PATTERN_LEN, v);
  endtask

  // one buffer; where the length fits, most carry the pattern, some a near miss, the rest pure noise
  task automatic send_buffer();
    logic [7:0] frame [];
    logic [127:0] pat;
    logic [127:0] msk;
    int n;
    int pos;
    int len;
    int k;
    pat = {pat_hi, pat_lo};
    msk = {msk_hi, msk_lo};
    len = pat_len;
    n = ($urandom_range(99) < 70) ? $urandom_range(1, 24) : $urandom_range(16, 64);
    frame = new[n];
    foreach (frame[i]) frame[i] = 8'($urandom_range(0, 255));
    if (len >= 1 && len <= mbps_pkg::MAX_PATTERN && n >= len &&
        $urandom_range(99) < 65) begin
      pos = $urandom_range(0, n - len);
      for (int j = 0; j < len; j++) begin
        frame[pos+j] = (pat[8*j +: 8] & msk[8*j +: 8]) | (frame[pos+j] & ~msk[8*j +: 8]);
      end
      if ($urandom_range(99) < 20) begin
        k = $urandom_range(0, len - 1);
        frame[pos+k] = frame[pos+k] ^ (msk[8*k +: 8] & (8'h01 << $urandom_range(0, 7)));
      end
    end
    for (int i = 0; i < n; i++) push_byte(frame[i], i == n - 1, 1'b0, NO_WANT);
  endtask

  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                           input bit squeeze);
    int unsigned start;
    int unsigned blk;
    int unsigned slot;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = bytes_sent;
    slot = 0;
    while (bytes_sent - start < PHASE_BYTES) begin
      settle();
      new_setting(slot);
      // long receiver hold-off while bytes keep coming, fills the block
      if (squeeze && slot == 0) hold_go = 1'b1;
      slot++;
      blk = bytes_sent;
      while (bytes_sent - blk < SETTING_BYTES && bytes_sent - start < PHASE_BYTES) begin
        send_buffer();
      end
    end
  endtask

  // receiver: random stall, or one long hold-off counted here
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  // result checker, compares each accepted transaction with the oldest prediction
  always @(posedge clk) begin
    mbps_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result: found=%0d offset=%0d overflow=%0d",
                   out_data.found, out_data.match_offset, out_data.overflow);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.found !== want.found || out_data.match_offset !== want.match_offset ||
            out_data.overflow !== want.overflow) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display({"mismatch: want found=%0d offset=%0d overflow=%0d, ",
                      "got found=%0d offset=%0d overflow=%0d"},
                     want.found, want.match_offset, want.overflow,
                     out_data.found, out_data.match_offset, out_data.overflow);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    pat_lo  = '0;
    pat_hi  = '0;
    msk_lo  = '0;
    msk_hi  = '0;
    pat_len = '0;
    clear_search();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, no idling
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == STEP_WRITE) begin
        settle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
      end else begin
        push_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // random part: sender idles lightly and receiver heavily, then the reverse, then no idling
    run_phase(20, 73, 1'b0);
    run_phase(73, 20, 1'b0);
    run_phase(0, 0, 1'b1);

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
